// ----- hw/rtl/ipd_pkg.sv -----
`default_nettype none
package ipd_pkg;

  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned REG_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  // Request kinds on the input channel
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_EDGE = 2'd1;
  localparam logic [1:0] REQ_ACK  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TMO_RELOAD = 2'd3;

  // Classified operations handed from front to back
  localparam int unsigned OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd1;
  localparam logic [OP_W-1:0] OP_ACK       = 3'd2;
  localparam logic [OP_W-1:0] OP_EDGE_OVF  = 3'd3;
  localparam logic [OP_W-1:0] OP_EDGE_ZERO = 3'd4;
  localparam logic [OP_W-1:0] OP_EDGE_ONE  = 3'd5;
  localparam logic [OP_W-1:0] OP_EDGE_NOIS = 3'd6;

  typedef logic [OP_W-1:0] op_t;

  typedef struct packed {
    logic vld;
    op_t  op;
  } qent_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ipd_if.sv -----
`default_nettype none
interface ipd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] edge_interval;
  logic       interval_overflow;

  modport source (output valid, output req_type, output edge_interval,
                  output interval_overflow, input ready);
  modport sink   (input valid, input req_type, input edge_interval,
                  input interval_overflow, output ready);
endinterface

interface ipd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        frame_ready;
  logic [ipd_pkg::DATA_W-1:0]  frame_data;
  logic [ipd_pkg::CNT_W-1:0]   bits_received;
  logic                        restart_timer;

  modport source (output valid, output frame_ready, output frame_data,
                  output bits_received, output restart_timer, input ready);
  modport sink   (input valid, input frame_ready, input frame_data,
                  input bits_received, input restart_timer, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ipd_front.sv -----
`default_nettype none
module ipd_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ipd_pkg::REG_W-1:0]      cfg_wdata,
  input  wire logic                           in_valid,
  input  wire logic [1:0]                     in_req_type,
  input  wire logic [7:0]                     in_edge_interval,
  input  wire logic                           in_interval_overflow,
  input  wire logic                           q_full,
  output      logic                           in_ready,
  output      ipd_pkg::qent_t                 push,
  output      logic [ipd_pkg::REG_W-1:0]      tmo_reload
);

  logic [ipd_pkg::REG_W-1:0] zero_low_r;
  logic [ipd_pkg::REG_W-1:0] split_r;
  logic [ipd_pkg::REG_W-1:0] one_high_r;
  logic [ipd_pkg::REG_W-1:0] tmo_reload_r;
  logic                      in_zero;
  logic                      in_one;
  ipd_pkg::op_t              op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_low_r   <= 8'd20;
      split_r      <= 8'd50;
      one_high_r   <= 8'd90;
      tmo_reload_r <= 8'd150;
    end else if (cfg_we) begin
      case (cfg_index)
        ipd_pkg::CFG_ZERO_LOW:   zero_low_r   <= cfg_wdata;
        ipd_pkg::CFG_SPLIT:      split_r      <= cfg_wdata;
        ipd_pkg::CFG_ONE_HIGH:   one_high_r   <= cfg_wdata;
        ipd_pkg::CFG_TMO_RELOAD: tmo_reload_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_zero = (in_edge_interval > zero_low_r) && (in_edge_interval < split_r);
  assign in_one  = (in_edge_interval > split_r) && (in_edge_interval < one_high_r);

  // Overflow beats both windows; the zero window beats the one window.
  always_comb begin
    case (in_req_type)
      ipd_pkg::REQ_TICK: op = ipd_pkg::OP_TICK;
      ipd_pkg::REQ_ACK:  op = ipd_pkg::OP_ACK;
      ipd_pkg::REQ_EDGE: begin
        if (in_interval_overflow)  op = ipd_pkg::OP_EDGE_OVF;
        else if (in_zero)          op = ipd_pkg::OP_EDGE_ZERO;
        else if (in_one)           op = ipd_pkg::OP_EDGE_ONE;
        else                       op = ipd_pkg::OP_EDGE_NOIS;
      end
      default: op = ipd_pkg::OP_NOP;
    endcase
  end

  assign in_ready   = !q_full;
  assign push.vld   = in_valid && !q_full;
  assign push.op    = op;
  assign tmo_reload = tmo_reload_r;

endmodule
`default_nettype wire

// ----- hw/rtl/ipd_queue.sv -----
`default_nettype none
module ipd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ipd_pkg::qent_t  push,
  input  wire logic            pop,
  output      logic            full,
  output      ipd_pkg::qent_t  head
);

  ipd_pkg::op_t mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;
  logic         do_pop;

  assign full     = (cnt_r == 2'd2);
  assign do_pop   = pop && (cnt_r != 2'd0);
  assign head.vld = (cnt_r != 2'd0);
  assign head.op  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.vld && !do_pop)      cnt_nxt = cnt_r + 2'd1;
    else if (!push.vld && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push.vld) mem_r[wr_ptr_r] <= push.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push.vld) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)   rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ipd_back.sv -----
`default_nettype none
module ipd_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ipd_pkg::qent_t                head,
  input  wire logic [ipd_pkg::REG_W-1:0]     tmo_reload,
  output      logic                          pop,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          out_frame_ready,
  output      logic [ipd_pkg::DATA_W-1:0]    out_frame_data,
  output      logic [ipd_pkg::CNT_W-1:0]     out_bits_received,
  output      logic                          out_restart_timer
);

  localparam logic [ipd_pkg::CNT_W-1:0] FULL_CNT = ipd_pkg::CNT_W'(ipd_pkg::FRAME_BITS);

  logic                        armed_r, armed_nxt;
  logic [ipd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ipd_pkg::DATA_W-1:0]  data_r, data_nxt;
  logic [ipd_pkg::REG_W-1:0]   tmo_r, tmo_nxt;
  logic                        rdy_r, rdy_nxt;
  logic                        restart;
  logic                        out_vld_r;
  logic                        restart_r;
  logic                        take_edge;

  assign pop       = head.vld && (!out_vld_r || out_ready);
  assign take_edge = (cnt_r < FULL_CNT) && !rdy_r;

  always_comb begin
    armed_nxt = armed_r;
    cnt_nxt   = cnt_r;
    data_nxt  = data_r;
    tmo_nxt   = tmo_r;
    rdy_nxt   = rdy_r;
    restart   = 1'b0;
    case (head.op)
      ipd_pkg::OP_TICK: begin
        if (tmo_r != '0) begin
          tmo_nxt = tmo_r - 1'b1;
          if (tmo_r == 8'd1) begin
            cnt_nxt = '0;
            if (cnt_r == FULL_CNT) begin
              rdy_nxt = 1'b1;
            end else begin
              armed_nxt = 1'b0;
              restart   = 1'b1;
            end
          end
        end
      end
      ipd_pkg::OP_ACK: rdy_nxt = 1'b0;
      ipd_pkg::OP_EDGE_OVF, ipd_pkg::OP_EDGE_ZERO,
      ipd_pkg::OP_EDGE_ONE, ipd_pkg::OP_EDGE_NOIS: begin
        tmo_nxt = tmo_reload;
        if (take_edge) begin
          if (!armed_r) begin
            armed_nxt = 1'b1;
            restart   = 1'b1;
          end else if (head.op == ipd_pkg::OP_EDGE_OVF) begin
            cnt_nxt  = '0;
            data_nxt = '0;
            restart  = 1'b1;
          end else if (head.op != ipd_pkg::OP_EDGE_NOIS) begin
            cnt_nxt  = cnt_r + 1'b1;
            data_nxt = {data_r[ipd_pkg::DATA_W-2:0], head.op == ipd_pkg::OP_EDGE_ONE};
            restart  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      cnt_r     <= '0;
      data_r    <= '0;
      tmo_r     <= '0;
      rdy_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (pop) begin
        armed_r <= armed_nxt;
        cnt_r   <= cnt_nxt;
        data_r  <= data_nxt;
        tmo_r   <= tmo_nxt;
        rdy_r   <= rdy_nxt;
      end
      if (pop)            out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) restart_r <= restart;
  end

  assign out_valid         = out_vld_r;
  assign out_frame_ready   = rdy_r;
  assign out_frame_data    = data_r;
  assign out_bits_received = cnt_r;
  assign out_restart_timer = restart_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT) else $error("bit count beyond frame length");
  a_ready_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    rdy_r |-> cnt_r == '0) else $error("frame ready with nonzero count");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == '0 || cnt_r == $past(cnt_r) + 1'b1))
    else $error("bit count jumped");
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(pop) |-> $stable(data_r) && $stable(cnt_r))
    else $error("state moved without a dequeued op");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/ir_pulse_distance_decoder_core.sv -----
`default_nettype none
// Pulse-distance IR frame decoder. Each transfer on in_ch is one event (1 ms
// tick, falling edge with measured interval and overflow flag, or frame
// acknowledge) and yields exactly one transfer on out_ch carrying the ready
// flag, the 32-bit shift data, the bit count and a restart request for the
// external interval timer, all as they stand after the event. The front
// classifies each event against the window registers, a two-entry queue holds
// the classified op, and the back applies it to the frame state into an
// output register. One event per cycle is sustained while out_ch stays ready;
// each result is registered by the queue write and then by the output
// register. Write cfg_* only while no event is in flight: index 0 zero_low,
// 1 zero_one_split, 2 one_high, 3 timeout_reload.
module ir_pulse_distance_decoder_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ipd_pkg::REG_W-1:0]      cfg_wdata,
  ipd_in_if.sink                              in_ch,
  ipd_out_if.source                           out_ch
);

  ipd_pkg::qent_t             push;
  ipd_pkg::qent_t             head;
  logic                       q_full;
  logic                       pop;
  logic [ipd_pkg::REG_W-1:0]  tmo_reload;

  // Front: hold config, classify events, push into the queue.
  ipd_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_ch.valid),
    .in_req_type          (in_ch.req_type),
    .in_edge_interval     (in_ch.edge_interval),
    .in_interval_overflow (in_ch.interval_overflow),
    .q_full               (q_full),
    .in_ready             (in_ch.ready),
    .push                 (push),
    .tmo_reload           (tmo_reload)
  );

  // Queue: decouple front stalls from output backpressure.
  ipd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // Back: advance the frame state and register the result.
  ipd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .tmo_reload        (tmo_reload),
    .pop               (pop),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_frame_ready   (out_ch.frame_ready),
    .out_frame_data    (out_ch.frame_data),
    .out_bits_received (out_ch.bits_received),
    .out_restart_timer (out_ch.restart_timer)
  );

endmodule
`default_nettype wire
